// ===== rtl/ffa_pkg.sv =====
// Shared constants, the command code and the status bundle for the allocator.
// No dependencies; used by ffa_ctrl, ffa_dp and the top level.
package ffa_pkg;

  localparam int unsigned POOL_QUANTA_DEF     = 4096;
  localparam int unsigned QUANTUM_BYTES_DEF   = 8;
  localparam int unsigned MIN_GROW_QUANTA_DEF = 16;

  localparam int unsigned CFG_W    = 13;  // pool_quanta register
  localparam int unsigned BYTES_W  = 16;  // request_bytes field
  localparam int unsigned ADDR_W   = 12;  // block_address / given_address fields
  localparam int unsigned NEED_W   = 16;  // quanta needed by one request
  localparam int unsigned RECIP_SH = 20;  // reciprocal scale for the byte-to-quanta step

  localparam logic [CFG_W-1:0] POOL_RESET = CFG_W'(4096);

  typedef enum logic [4:0] {
    CMD_NOP,
    CMD_MUL,
    CMD_NEED,
    CMD_AINIT,
    CMD_ARL,
    CMD_AP,
    CMD_ASZ,
    CMD_ARLP,
    CMD_AUNL,
    CMD_ASP1,
    CMD_ASP2,
    CMD_AADV,
    CMD_GWR,
    CMD_GEND,
    CMD_RINIT,
    CMD_RRD,
    CMD_RNX,
    CMD_RADV,
    CMD_RRDSB,
    CMD_RSB,
    CMD_RSN,
    CMD_RWHI,
    CMD_RRDSP,
    CMD_RSP,
    CMD_RWLO,
    CMD_FAIL
  } cmd_e;

  typedef struct packed {
    logic is_free;    // current word is a free
    logic free_ok;    // free address is usable
    logic steps_ovf;  // allocate walk ran too long
    logic fit;        // current block is large enough
    logic exact;      // current block matches exactly
    logic at_rover;   // walk came back to the rover
    logic grow_ok;    // fresh quanta are available
    logic found;      // release walk found its slot
    logic rwalk_ovf;  // release walk ran too long
  } stat_t;

endpackage

// ===== rtl/ffa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffa_ram #(
  parameter int unsigned WIDTH = 13,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/ffa_ctrl.sv =====
// Sequencer for the allocator: steps through allocate, grow and release.
// Depends on ffa_pkg.
module ffa_ctrl
  import ffa_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  input  stat_t stat_i,
  output cmd_e  cmd_o,
  output logic  idle_o,
  output logic  done_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_MUL, S_NEED, S_FCHK, S_AINIT, S_ARL, S_AP, S_ASZ, S_ADEC, S_AADV,
    S_ARLP, S_AUNL, S_ASP1, S_ASP2, S_GCHK, S_GWR, S_GEND, S_RINIT, S_RRD,
    S_RNX, S_RDEC, S_RADV, S_RRDSB, S_RSB, S_RSN, S_RWHI, S_RRDSP, S_RSP,
    S_RWLO, S_REND, S_FAIL, S_DONE
  } state_e;

  state_e state_q;
  logic   ret_grow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      ret_grow_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE:  if (start_i) state_q <= S_MUL;
        S_MUL:   state_q <= S_NEED;
        S_NEED:  state_q <= stat_i.is_free ? S_FCHK : S_AINIT;
        S_FCHK: begin
          ret_grow_q <= 1'b0;
          state_q    <= stat_i.free_ok ? S_RINIT : S_DONE;
        end
        S_AINIT: state_q <= S_ARL;
        S_ARL:   state_q <= S_AP;
        S_AP:    state_q <= S_ASZ;
        S_ASZ:   state_q <= S_ADEC;
        S_ADEC: begin
          if (stat_i.steps_ovf)   state_q <= S_FAIL;
          else if (stat_i.fit)    state_q <= stat_i.exact ? S_ARLP : S_ASP1;
          else if (stat_i.at_rover) state_q <= S_GCHK;
          else                    state_q <= S_AADV;
        end
        S_AADV:  state_q <= S_ARL;
        S_ARLP:  state_q <= S_AUNL;
        S_AUNL:  state_q <= S_DONE;
        S_ASP1:  state_q <= S_ASP2;
        S_ASP2:  state_q <= S_DONE;
        S_GCHK:  state_q <= stat_i.grow_ok ? S_GWR : S_FAIL;
        S_GWR: begin
          ret_grow_q <= 1'b1;
          state_q    <= S_RINIT;
        end
        S_GEND:  state_q <= S_ARL;
        S_RINIT: state_q <= S_RRD;
        S_RRD:   state_q <= S_RNX;
        S_RNX:   state_q <= S_RDEC;
        S_RDEC: begin
          if (stat_i.found)          state_q <= S_RRDSB;
          else if (stat_i.rwalk_ovf) state_q <= S_REND;
          else                       state_q <= S_RADV;
        end
        S_RADV:  state_q <= S_RRD;
        S_RRDSB: state_q <= S_RSB;
        S_RSB:   state_q <= S_RSN;
        S_RSN:   state_q <= S_RWHI;
        S_RWHI:  state_q <= S_RRDSP;
        S_RRDSP: state_q <= S_RSP;
        S_RSP:   state_q <= S_RWLO;
        S_RWLO:  state_q <= S_REND;
        S_REND:  state_q <= ret_grow_q ? S_GEND : S_DONE;
        S_FAIL:  state_q <= S_DONE;
        S_DONE:  state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    unique case (state_q)
      S_MUL:   cmd_o = CMD_MUL;
      S_NEED:  cmd_o = CMD_NEED;
      S_AINIT: cmd_o = CMD_AINIT;
      S_ARL:   cmd_o = CMD_ARL;
      S_AP:    cmd_o = CMD_AP;
      S_ASZ:   cmd_o = CMD_ASZ;
      S_AADV:  cmd_o = CMD_AADV;
      S_ARLP:  cmd_o = CMD_ARLP;
      S_AUNL:  cmd_o = CMD_AUNL;
      S_ASP1:  cmd_o = CMD_ASP1;
      S_ASP2:  cmd_o = CMD_ASP2;
      S_GWR:   cmd_o = CMD_GWR;
      S_GEND:  cmd_o = CMD_GEND;
      S_RINIT: cmd_o = CMD_RINIT;
      S_RRD:   cmd_o = CMD_RRD;
      S_RNX:   cmd_o = CMD_RNX;
      S_RADV:  cmd_o = CMD_RADV;
      S_RRDSB: cmd_o = CMD_RRDSB;
      S_RSB:   cmd_o = CMD_RSB;
      S_RSN:   cmd_o = CMD_RSN;
      S_RWHI:  cmd_o = CMD_RWHI;
      S_RRDSP: cmd_o = CMD_RRDSP;
      S_RSP:   cmd_o = CMD_RSP;
      S_RWLO:  cmd_o = CMD_RWLO;
      S_FAIL:  cmd_o = CMD_FAIL;
      default: cmd_o = CMD_NOP;
    endcase
  end

  assign idle_o = (state_q == S_IDLE);
  assign done_o = (state_q == S_DONE);

endmodule

// ===== rtl/ffa_dp.sv =====
// Datapath: list registers, size and link memories, and the compares the
// sequencer branches on. Depends on ffa_pkg and ffa_ram.
module ffa_dp
  import ffa_pkg::*;
#(
  parameter int unsigned POOL_QUANTA     = POOL_QUANTA_DEF,
  parameter int unsigned QUANTUM_BYTES   = QUANTUM_BYTES_DEF,
  parameter int unsigned MIN_GROW_QUANTA = MIN_GROW_QUANTA_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               op_i,
  input  logic [BYTES_W-1:0] bytes_i,
  input  logic [ADDR_W-1:0]  addr_i,
  input  logic               cfg_we_i,
  input  logic [CFG_W-1:0]   cfg_wdata_i,
  input  cmd_e               cmd_i,
  output stat_t              stat_o,
  output logic [ADDR_W-1:0]  given_o,
  output logic               fail_o
);

  localparam int unsigned AW      = $clog2(POOL_QUANTA + 1);
  localparam int unsigned IW      = $clog2(POOL_QUANTA);
  localparam int unsigned WALK    = POOL_QUANTA + 2;
  localparam int unsigned SW      = $clog2(2 * WALK + 2);
  localparam int unsigned RECIP   = (1 << RECIP_SH) / QUANTUM_BYTES;
  localparam int unsigned RECIP_W = $clog2(RECIP + 1);
  localparam int unsigned XW      = BYTES_W + 1;
  localparam int unsigned PW      = XW + RECIP_W;
  localparam int unsigned QW      = $clog2(QUANTUM_BYTES + 1);
  localparam int unsigned RW      = XW + QW;
  localparam int unsigned CW      = ((AW > NEED_W) ? AW : NEED_W) + 1;
  localparam int unsigned FW      = ((AW > ADDR_W) ? AW : ADDR_W) + 1;

  logic              op_q;
  logic [ADDR_W-1:0] addr_q;
  logic [XW-1:0]     x_q;
  logic [PW-1:0]     prod_q;
  logic [NEED_W-1:0] need_q;
  logic [AW-1:0]     blk_q, prev_q, p_q, nx_q, rover_q, sent_q, carved_q;
  logic [AW-1:0]     sz_q, sb_q, sn_q, lb_q, given_q;
  logic [AW-1:0]     ridl_q, rids_q;
  logic [SW-1:0]     steps_q, rsteps_q;
  logic              started_q, fail_q;
  logic [CFG_W-1:0]  pool_q;

  logic [AW-1:0] s_rdata, l_rdata, link_val, size_val;
  logic [AW-1:0] rd_l, rd_s;
  logic          sw_en, lw_en;
  logic [AW-1:0] sw_id, lw_id, sw_data, lw_data;
  logic [AW-1:0] sw_idx, lw_idx, rl_idx, rs_idx;

  logic [XW-1:0]     q0;
  logic [RW-1:0]     rem;
  logic [NEED_W-1:0] grow_n;
  logic [CW-1:0]     limit;
  logic              hi_merge, lo_merge;

  assign link_val = (ridl_q == '0) ? sent_q : l_rdata;
  assign size_val = (rids_q == '0) ? '0 : s_rdata;

  assign q0  = XW'(prod_q >> RECIP_SH);
  assign rem = RW'(x_q) - RW'(q0) * RW'(QUANTUM_BYTES);

  assign grow_n   = (need_q < NEED_W'(MIN_GROW_QUANTA)) ? NEED_W'(MIN_GROW_QUANTA) : need_q;
  assign limit    = (CW'(pool_q) < CW'(POOL_QUANTA)) ? CW'(pool_q) : CW'(POOL_QUANTA);
  assign hi_merge = ((AW + 1)'(blk_q) + (AW + 1)'(sb_q)) == (AW + 1)'(nx_q);
  assign lo_merge = ((AW + 1)'(p_q) + (AW + 1)'(sz_q)) == (AW + 1)'(blk_q);

  always_comb begin
    stat_o.is_free   = op_q;
    stat_o.free_ok   = (addr_q != '0) && started_q && (FW'(addr_q) <= FW'(POOL_QUANTA));
    stat_o.steps_ovf = steps_q > SW'(2 * WALK);
    stat_o.fit       = CW'(sz_q) >= CW'(need_q);
    stat_o.exact     = CW'(sz_q) == CW'(need_q);
    stat_o.at_rover  = (p_q == rover_q);
    stat_o.grow_ok   = (CW'(carved_q) + CW'(grow_n)) <= limit;
    stat_o.found     = ((blk_q > p_q) && (blk_q < nx_q)) ||
                       ((p_q >= nx_q) && ((blk_q > p_q) || (blk_q < nx_q)));
    stat_o.rwalk_ovf = (rsteps_q + 1'b1) > SW'(WALK);
  end

  // Memory port selection per command.
  always_comb begin
    rd_l    = '0;
    rd_s    = '0;
    sw_en   = 1'b0;
    sw_id   = '0;
    sw_data = '0;
    lw_en   = 1'b0;
    lw_id   = '0;
    lw_data = '0;
    case (cmd_i)
      CMD_ARL:  rd_l = prev_q;
      CMD_AP:   rd_s = link_val;
      CMD_ARLP: rd_l = p_q;
      CMD_AUNL: begin
        lw_en = 1'b1; lw_id = prev_q; lw_data = link_val;
      end
      CMD_ASP1: begin
        sw_en = 1'b1; sw_id = p_q; sw_data = sz_q - AW'(need_q);
      end
      CMD_ASP2: begin
        sw_en = 1'b1; sw_id = p_q; sw_data = AW'(need_q);
      end
      CMD_GWR: begin
        sw_en = 1'b1; sw_id = carved_q + 1'b1; sw_data = AW'(grow_n);
      end
      CMD_RRD:   rd_l = p_q;
      CMD_RRDSB: begin
        rd_s = blk_q; rd_l = nx_q;
      end
      CMD_RSB:   rd_s = nx_q;
      CMD_RWHI: begin
        lw_en = 1'b1;
        lw_id = blk_q;
        if (hi_merge) begin
          sw_en = 1'b1; sw_id = blk_q; sw_data = sb_q + sn_q; lw_data = lb_q;
        end else begin
          lw_data = nx_q;
        end
      end
      CMD_RRDSP: rd_s = p_q;
      CMD_RWLO: begin
        lw_en = 1'b1;
        lw_id = p_q;
        if (lo_merge) begin
          sw_en = 1'b1; sw_id = p_q; sw_data = sz_q + sb_q; lw_data = lb_q;
        end else begin
          lw_data = blk_q;
        end
      end
      default: ;
    endcase
  end

  // Header index is the block id minus one; id zero is the sentinel.
  assign sw_idx = sw_id - 1'b1;
  assign lw_idx = lw_id - 1'b1;
  assign rl_idx = rd_l - 1'b1;
  assign rs_idx = rd_s - 1'b1;

  ffa_ram #(.WIDTH(AW), .DEPTH(POOL_QUANTA)) u_size_ram (
    .clk_i   (clk_i),
    .we_i    (sw_en && (sw_id != '0)),
    .waddr_i (sw_idx[IW-1:0]),
    .wdata_i (sw_data),
    .raddr_i (rs_idx[IW-1:0]),
    .rdata_o (s_rdata)
  );

  ffa_ram #(.WIDTH(AW), .DEPTH(POOL_QUANTA)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (lw_en && (lw_id != '0)),
    .waddr_i (lw_idx[IW-1:0]),
    .wdata_i (lw_data),
    .raddr_i (rl_idx[IW-1:0]),
    .rdata_o (l_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      rover_q   <= '0;
      sent_q    <= '0;
      carved_q  <= '0;
      pool_q    <= POOL_RESET;
      op_q      <= 1'b0;
    end else begin
      if (cfg_we_i) pool_q <= cfg_wdata_i;
      if (start_i) op_q <= op_i;
      if (lw_en && (lw_id == '0)) sent_q <= lw_data;
      case (cmd_i)
        CMD_AINIT: begin
          if (!started_q) begin
            started_q <= 1'b1;
            rover_q   <= '0;
            sent_q    <= '0;
          end
        end
        CMD_AUNL, CMD_ASP2: rover_q <= prev_q;
        CMD_GEND:           carved_q <= carved_q + AW'(grow_n);
        CMD_RWLO:           rover_q <= p_q;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    ridl_q <= rd_l;
    rids_q <= rd_s;
    if (start_i) begin
      addr_q  <= addr_i;
      blk_q   <= AW'(addr_i);
      x_q     <= XW'(bytes_i) + XW'(QUANTUM_BYTES - 1);
      given_q <= '0;
      fail_q  <= 1'b0;
    end
    case (cmd_i)
      CMD_MUL:   prod_q <= PW'(x_q) * PW'(RECIP);
      CMD_NEED:  need_q <= NEED_W'(q0) + NEED_W'(rem >= RW'(QUANTUM_BYTES)) + 1'b1;
      CMD_AINIT: begin
        prev_q  <= started_q ? rover_q : '0;
        steps_q <= '0;
      end
      CMD_AP:    p_q <= link_val;
      CMD_ASZ:   sz_q <= size_val;
      CMD_AUNL:  given_q <= p_q;
      CMD_ASP1:  p_q <= p_q + sz_q - AW'(need_q);
      CMD_ASP2:  given_q <= p_q;
      CMD_AADV: begin
        prev_q  <= p_q;
        steps_q <= steps_q + 1'b1;
      end
      CMD_GWR:   blk_q <= carved_q + 1'b1;
      CMD_GEND: begin
        prev_q  <= rover_q;
        steps_q <= steps_q + 1'b1;
      end
      CMD_RINIT: begin
        p_q      <= rover_q;
        rsteps_q <= '0;
      end
      CMD_RNX:   nx_q <= link_val;
      CMD_RADV: begin
        p_q      <= nx_q;
        rsteps_q <= rsteps_q + 1'b1;
      end
      CMD_RSB: begin
        sb_q <= size_val;
        lb_q <= link_val;
      end
      CMD_RSN:   sn_q <= size_val;
      CMD_RWHI: begin
        if (hi_merge) sb_q <= sb_q + sn_q;
        else          lb_q <= nx_q;
      end
      CMD_RSP:   sz_q <= size_val;
      CMD_FAIL: begin
        fail_q  <= 1'b1;
        given_q <= '0;
      end
      default: ;
    endcase
  end

  assign given_o = ADDR_W'(given_q);
  assign fail_o  = fail_q;

endmodule

// ===== rtl/first_fit_free_list_allocator.sv =====
// First-fit free-list allocator: top level with stream ports and result register.
// An allocate walks blocks from the rover until one fits; a free walks from the rover to its
// slot, or is ignored; each carve of fresh quanta runs a release walk of its own.
// One word is in flight at a time; the next is taken as the result word leaves.
// Reset (async, active low) empties the list state and sets pool_quanta to 4096;
// the size and link memories are not cleared and need no clearing pass.
module first_fit_free_list_allocator
  import ffa_pkg::*;
#(
  parameter int unsigned POOL_QUANTA     = POOL_QUANTA_DEF,
  parameter int unsigned QUANTUM_BYTES   = QUANTUM_BYTES_DEF,
  parameter int unsigned MIN_GROW_QUANTA = MIN_GROW_QUANTA_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [31:0]      s_axis_tdata,   // [15:0] request_bytes, [27:16] block_address
  input  logic             s_axis_tuser,   // [0] operation (0 allocate, 1 free)
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [11:0] given_address
  output logic             m_axis_tuser,   // [0] failed
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i     // pool_quanta
);

  cmd_e              cmd;
  stat_t             stat;
  logic              idle, done, accept;
  logic              m_valid_q;
  logic [ADDR_W-1:0] given;
  logic              fail;

  // Take a word only when the sequencer is idle and the result slot is free
  // or draining this cycle.
  assign s_axis_tready = idle && (!m_valid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  ffa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (accept),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .idle_o  (idle),
    .done_o  (done)
  );

  ffa_dp #(
    .POOL_QUANTA     (POOL_QUANTA),
    .QUANTUM_BYTES   (QUANTUM_BYTES),
    .MIN_GROW_QUANTA (MIN_GROW_QUANTA)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept),
    .op_i        (s_axis_tuser),
    .bytes_i     (s_axis_tdata[15:0]),
    .addr_i      (s_axis_tdata[27:16]),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .given_o     (given),
    .fail_o      (fail)
  );

  // Hold the result word until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (done) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'b0000, given};
  assign m_axis_tuser  = fail;

endmodule
